[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[src/lix_pkg.sv]
// ----------------------------------------------------------------------------
// Line intersection package
// Shared constants, status codes and the classification word.
// ----------------------------------------------------------------------------
`default_nettype none
package lix_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;
  localparam int FIFO_DEPTH = 4;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  typedef struct packed {
    logic parallel;
    logic same_org;
    logic confined;
  } cls_t;

  localparam int CLS_BITS = $bits(cls_t);

  function automatic int word_bits(int cb);
    return CLS_BITS + 16 * cb + 7;
  endfunction
endpackage
`default_nettype wire

[src/lix_front.sv]
// ----------------------------------------------------------------------------
// Line intersection front end
// Forms products, determinant, cross products and segment bounds; classifies.
// ----------------------------------------------------------------------------
`default_nettype none
module lix_front #(
  parameter int CB = 24,
  parameter int WordBits = lix_pkg::word_bits(24)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [CB-1:0] dir_a_x_i,
  input  logic signed [CB-1:0] dir_a_y_i,
  input  logic signed [CB-1:0] org_a_x_i,
  input  logic signed [CB-1:0] org_a_y_i,
  input  logic signed [CB-1:0] dir_b_x_i,
  input  logic signed [CB-1:0] dir_b_y_i,
  input  logic signed [CB-1:0] org_b_x_i,
  input  logic signed [CB-1:0] org_b_y_i,
  input  logic                 confined_i,
  output logic                 push_o,
  output logic [WordBits-1:0]  word_o
);
  import lix_pkg::*;

  localparam int PW = 2 * CB;
  localparam int XW = 2 * CB + 1;
  localparam int EW = CB + 1;

  logic v1_q, v2_q;
  logic signed [PW-1:0] p_ab_q, p_ba_q, p_ca1_q, p_ca2_q, p_cb1_q, p_cb2_q;
  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q, oax_q, oay_q, obx_q, oby_q;
  logic signed [EW-1:0] eax_q, eay_q, ebx_q, eby_q;
  logic                 same_q, conf_q;
  logic [WordBits-1:0]  word_q;

  logic signed [XW-1:0] det_d, ca_d, cb_d;
  logic signed [EW-1:0] lox_d, hix_d, loy_d, hiy_d;
  logic signed [EW-1:0] mina_x, minb_x, maxa_x, maxb_x;
  logic signed [EW-1:0] mina_y, minb_y, maxa_y, maxb_y;
  cls_t                 cls_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_ab_q  <= PW'(dir_a_x_i) * PW'(dir_b_y_i);
    p_ba_q  <= PW'(dir_a_y_i) * PW'(dir_b_x_i);
    p_ca1_q <= PW'(org_a_x_i) * PW'(dir_a_y_i);
    p_ca2_q <= PW'(org_a_y_i) * PW'(dir_a_x_i);
    p_cb1_q <= PW'(org_b_x_i) * PW'(dir_b_y_i);
    p_cb2_q <= PW'(org_b_y_i) * PW'(dir_b_x_i);
    ax_q    <= dir_a_x_i;
    ay_q    <= dir_a_y_i;
    bx_q    <= dir_b_x_i;
    by_q    <= dir_b_y_i;
    oax_q   <= org_a_x_i;
    oay_q   <= org_a_y_i;
    obx_q   <= org_b_x_i;
    oby_q   <= org_b_y_i;
    eax_q   <= EW'(org_a_x_i) + EW'(dir_a_x_i);
    eay_q   <= EW'(org_a_y_i) + EW'(dir_a_y_i);
    ebx_q   <= EW'(org_b_x_i) + EW'(dir_b_x_i);
    eby_q   <= EW'(org_b_y_i) + EW'(dir_b_y_i);
    same_q  <= (org_a_x_i == org_b_x_i) && (org_a_y_i == org_b_y_i);
    conf_q  <= confined_i;
  end

  always_comb begin
    det_d = XW'(p_ab_q) - XW'(p_ba_q);
    ca_d  = XW'(p_ca1_q) - XW'(p_ca2_q);
    cb_d  = XW'(p_cb1_q) - XW'(p_cb2_q);
    cls_d.parallel = (p_ab_q == p_ba_q);
    cls_d.same_org = same_q;
    cls_d.confined = conf_q;
    mina_x = (EW'(oax_q) < eax_q) ? EW'(oax_q) : eax_q;
    maxa_x = (EW'(oax_q) > eax_q) ? EW'(oax_q) : eax_q;
    minb_x = (EW'(obx_q) < ebx_q) ? EW'(obx_q) : ebx_q;
    maxb_x = (EW'(obx_q) > ebx_q) ? EW'(obx_q) : ebx_q;
    mina_y = (EW'(oay_q) < eay_q) ? EW'(oay_q) : eay_q;
    maxa_y = (EW'(oay_q) > eay_q) ? EW'(oay_q) : eay_q;
    minb_y = (EW'(oby_q) < eby_q) ? EW'(oby_q) : eby_q;
    maxb_y = (EW'(oby_q) > eby_q) ? EW'(oby_q) : eby_q;
    lox_d = (mina_x > minb_x) ? mina_x : minb_x;
    hix_d = (maxa_x < maxb_x) ? maxa_x : maxb_x;
    loy_d = (mina_y > minb_y) ? mina_y : minb_y;
    hiy_d = (maxa_y < maxb_y) ? maxa_y : maxb_y;
  end

  always_ff @(posedge clk_i) begin
    word_q <= {cls_d, det_d, ca_d, cb_d, ax_q, ay_q, bx_q, by_q, oax_q, oay_q,
               lox_d, hix_d, loy_d, hiy_d};
  end

  assign push_o = v2_q;
  assign word_o = word_q;
endmodule
`default_nettype wire

[src/lix_fifo.sv]
// ----------------------------------------------------------------------------
// Line intersection queue
// Short queue between front end and back end; pops whenever not empty.
// ----------------------------------------------------------------------------
`default_nettype none
module lix_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic         busy_o
);
  import lix_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [W-1:0]  mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];
  // leave room for the words still inside the front end
  assign busy_o  = (cnt_q >= CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end
endmodule
`default_nettype wire

[src/lix_div.sv]
// ----------------------------------------------------------------------------
// Line intersection divider
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module lix_div #(
  parameter int NW = 74,
  parameter int DW = 49,
  parameter int SW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_x_i,
  input  logic signed [NW-1:0] num_y_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [NW:0]   quo_x_o,
  output logic signed [NW:0]   quo_y_o,
  output logic [SW-1:0]        side_o
);
  localparam int QW = NW + 1;

  logic [NW:0]   vs_q;
  logic [NW-1:0] numx_q [NW+1];
  logic [NW-1:0] numy_q [NW+1];
  logic [NW-1:0] qx_q [NW+1];
  logic [NW-1:0] qy_q [NW+1];
  logic [DW-1:0] rx_q [NW+1];
  logic [DW-1:0] ry_q [NW+1];
  logic [DW-1:0] dm_q [NW+1];
  logic [NW:0]   negx_q, negy_q;
  logic [SW-1:0] side_q [NW+1];

  logic                 vo_q;
  logic signed [QW-1:0] ox_q, oy_q;
  logic [SW-1:0]        so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
      vo_q <= 1'b0;
    end else begin
      vs_q <= {vs_q[NW-1:0], valid_i};
      vo_q <= vs_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    numx_q[0] <= num_x_i[NW-1] ? -num_x_i : num_x_i;
    numy_q[0] <= num_y_i[NW-1] ? -num_y_i : num_y_i;
    dm_q[0]   <= den_i[DW-1] ? -den_i : den_i;
    negx_q[0] <= num_x_i[NW-1] ^ den_i[DW-1];
    negy_q[0] <= num_y_i[NW-1] ^ den_i[DW-1];
    rx_q[0]   <= '0;
    ry_q[0]   <= '0;
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] tx, ty, dd;
    logic        gex, gey;
    always_comb begin
      dd  = {1'b0, dm_q[s]};
      tx  = {rx_q[s], numx_q[s][NW-1]};
      ty  = {ry_q[s], numy_q[s][NW-1]};
      gex = (tx >= dd);
      gey = (ty >= dd);
    end
    always_ff @(posedge clk_i) begin
      rx_q[s+1]   <= gex ? DW'(tx - dd) : tx[DW-1:0];
      ry_q[s+1]   <= gey ? DW'(ty - dd) : ty[DW-1:0];
      qx_q[s+1]   <= {qx_q[s][NW-2:0], gex};
      qy_q[s+1]   <= {qy_q[s][NW-2:0], gey};
      numx_q[s+1] <= {numx_q[s][NW-2:0], 1'b0};
      numy_q[s+1] <= {numy_q[s][NW-2:0], 1'b0};
      dm_q[s+1]   <= dm_q[s];
      negx_q[s+1] <= negx_q[s];
      negy_q[s+1] <= negy_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= negx_q[NW] ? -QW'({1'b0, qx_q[NW]}) : QW'({1'b0, qx_q[NW]});
    oy_q <= negy_q[NW] ? -QW'({1'b0, qy_q[NW]}) : QW'({1'b0, qy_q[NW]});
    so_q <= side_q[NW];
  end

  assign valid_o = vo_q;
  assign quo_x_o = ox_q;
  assign quo_y_o = oy_q;
  assign side_o  = so_q;
endmodule
`default_nettype wire

[src/lix_back.sv]
// ----------------------------------------------------------------------------
// Line intersection back end
// Forms numerators, divides, applies the parallel, same-origin and segment tests and saturates.
// ----------------------------------------------------------------------------
`default_nettype none
module lix_back #(
  parameter int CB = 24,
  parameter int WordBits = lix_pkg::word_bits(24)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [WordBits-1:0]            word_i,
  input  logic [lix_pkg::TOL_BITS-1:0]   tol_i,
  output logic                           done_o,
  output logic signed [CB-1:0]           hit_x_o,
  output logic signed [CB-1:0]           hit_y_o,
  output logic [1:0]                     status_o
);
  import lix_pkg::*;

  localparam int XW = 2 * CB + 1;
  localparam int EW = CB + 1;
  localparam int LW = CB + 1;
  localparam int HW = XW - LW;
  localparam int BW = ((EW > TOL_BITS + 1) ? EW : TOL_BITS + 1) + 1;
  localparam int MW = XW + CB;
  localparam int NW = MW + 1;
  localparam int QW = NW + 1;
  localparam int PH = HW + CB;
  localparam int PL = LW + 1 + CB;
  localparam int SW = CLS_BITS + 2 * CB + 4 * BW;
  localparam logic signed [QW-1:0] QMAX = QW'({1'b0, {(CB-1){1'b1}}});
  localparam logic signed [QW-1:0] QMIN = -QMAX - 1;

  cls_t                 cls_w;
  logic signed [XW-1:0] det_w, ca_w, cb_w;
  logic signed [CB-1:0] ax_w, ay_w, bx_w, by_w, oax_w, oay_w;
  logic signed [EW-1:0] lox_w, hix_w, loy_w, hiy_w;

  assign {cls_w, det_w, ca_w, cb_w, ax_w, ay_w, bx_w, by_w, oax_w, oay_w,
          lox_w, hix_w, loy_w, hiy_w} = word_i;

  logic v1_q, v2_q, v3_q;
  logic signed [PH-1:0] hcbax_q, hcabx_q, hcbay_q, hcaby_q;
  logic signed [PL-1:0] lcbax_q, lcabx_q, lcbay_q, lcaby_q;
  logic signed [MW-1:0] cbax_q, cabx_q, cbay_q, caby_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [XW-1:0] det1_q, det2_q, det3_q;
  logic [SW-1:0]        side1_q, side2_q, side3_q;
  logic signed [LW:0]   ca_lo, cb_lo;
  logic signed [HW-1:0] ca_hi, cb_hi;
  logic signed [BW-1:0] lox_t, hix_t, loy_t, hiy_t;

  always_comb begin
    ca_lo = {1'b0, ca_w[LW-1:0]};
    cb_lo = {1'b0, cb_w[LW-1:0]};
    ca_hi = ca_w[XW-1:LW];
    cb_hi = cb_w[XW-1:LW];
    lox_t = BW'(lox_w) - BW'(tol_i);
    loy_t = BW'(loy_w) - BW'(tol_i);
    hix_t = BW'(hix_w) + BW'(tol_i);
    hiy_t = BW'(hiy_w) + BW'(tol_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hcbax_q <= PH'(cb_hi) * PH'(ax_w);
    hcabx_q <= PH'(ca_hi) * PH'(bx_w);
    hcbay_q <= PH'(cb_hi) * PH'(ay_w);
    hcaby_q <= PH'(ca_hi) * PH'(by_w);
    lcbax_q <= PL'(cb_lo) * PL'(ax_w);
    lcabx_q <= PL'(ca_lo) * PL'(bx_w);
    lcbay_q <= PL'(cb_lo) * PL'(ay_w);
    lcaby_q <= PL'(ca_lo) * PL'(by_w);
    det1_q  <= det_w;
    side1_q <= {cls_w, oax_w, oay_w, lox_t, hix_t, loy_t, hiy_t};

    cbax_q  <= (MW'(hcbax_q) <<< LW) + MW'(lcbax_q);
    cabx_q  <= (MW'(hcabx_q) <<< LW) + MW'(lcabx_q);
    cbay_q  <= (MW'(hcbay_q) <<< LW) + MW'(lcbay_q);
    caby_q  <= (MW'(hcaby_q) <<< LW) + MW'(lcaby_q);
    det2_q  <= det1_q;
    side2_q <= side1_q;

    nx_q    <= NW'(cbax_q) - NW'(cabx_q);
    ny_q    <= NW'(cbay_q) - NW'(caby_q);
    det3_q  <= det2_q;
    side3_q <= side2_q;
  end

  logic                 dv;
  logic signed [QW-1:0] qx, qy;
  logic [SW-1:0]        side_o;

  lix_div #(.NW(NW), .DW(XW), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_x_i (nx_q),
    .num_y_i (ny_q),
    .den_i   (det3_q),
    .side_i  (side3_q),
    .valid_o (dv),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (side_o)
  );

  cls_t                 cls_f;
  logic signed [CB-1:0] oax_f, oay_f;
  logic signed [BW-1:0] lox_f, hix_f, loy_f, hiy_f;
  logic                 out_x, out_y, sat_x, sat_y;
  logic signed [CB-1:0] cx, cy, hx_d, hy_d;
  logic [1:0]           st_d;

  assign {cls_f, oax_f, oay_f, lox_f, hix_f, loy_f, hiy_f} = side_o;

  always_comb begin
    out_x = (qx < QW'(lox_f)) || (qx > QW'(hix_f));
    out_y = (qy < QW'(loy_f)) || (qy > QW'(hiy_f));
    sat_x = (qx < QMIN) || (qx > QMAX);
    sat_y = (qy < QMIN) || (qy > QMAX);
    cx = (qx < QMIN) ? CB'(QMIN) : ((qx > QMAX) ? CB'(QMAX) : qx[CB-1:0]);
    cy = (qy < QMIN) ? CB'(QMIN) : ((qy > QMAX) ? CB'(QMAX) : qy[CB-1:0]);
    priority if (cls_f.parallel) begin
      hx_d = '0;
      hy_d = '0;
      st_d = ST_PARALLEL;
    end else if (cls_f.same_org) begin
      hx_d = oax_f;
      hy_d = oay_f;
      st_d = ST_HIT;
    end else if (cls_f.confined && (out_x || out_y)) begin
      hx_d = '0;
      hy_d = '0;
      st_d = ST_OUTSIDE;
    end else begin
      hx_d = cx;
      hy_d = cy;
      st_d = (sat_x || sat_y) ? ST_SAT : ST_HIT;
    end
  end

  logic                 done_q;
  logic signed [CB-1:0] hx_q, hy_q;
  logic [1:0]           st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    hx_q <= hx_d;
    hy_q <= hy_d;
    st_q <= st_d;
  end

  assign done_o   = done_q;
  assign hit_x_o  = hx_q;
  assign hit_y_o  = hy_q;
  assign status_o = st_q;
endmodule
`default_nettype wire

[src/line_intersection_2d.sv]
// ----------------------------------------------------------------------------
// Line intersection 2D
// Intersection of two lines given as origin and direction, signed fixed point.
//
// A word is taken at a rising edge with start_i high and busy_o low; the
// block takes one word per cycle and busy_o stays low in steady operation.
// Each word gives exactly one result: done_o is high for one cycle with
// hit_x_o, hit_y_o and status_o (hit, parallel, outside, saturated).
// A word passes two front end stages, the queue, three numerator stages and
// the divider: one stage per quotient bit (3*COORD_BITS + 2) plus sign and
// output stages. Results come out in the order the words went in. The
// receiver cannot stall; results are presented once and must be taken.
// The user must write bound_tolerance through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this.
// Reset clears all valid state and sets bound_tolerance to 1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module line_intersection_2d #(
  parameter int COORD_BITS = lix_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [lix_pkg::TOL_BITS-1:0]  cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]  dir_a_x_i,
  input  logic signed [COORD_BITS-1:0]  dir_a_y_i,
  input  logic signed [COORD_BITS-1:0]  org_a_x_i,
  input  logic signed [COORD_BITS-1:0]  org_a_y_i,
  input  logic signed [COORD_BITS-1:0]  dir_b_x_i,
  input  logic signed [COORD_BITS-1:0]  dir_b_y_i,
  input  logic signed [COORD_BITS-1:0]  org_b_x_i,
  input  logic signed [COORD_BITS-1:0]  org_b_y_i,
  input  logic                          confined_i,
  output logic                          done_o,
  output logic signed [COORD_BITS-1:0]  hit_x_o,
  output logic signed [COORD_BITS-1:0]  hit_y_o,
  output logic [1:0]                    status_o
);
  import lix_pkg::*;

  localparam int WB = word_bits(COORD_BITS);
  localparam logic signed [COORD_BITS-1:0] HMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] HMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [TOL_BITS-1:0] tol_q;
  logic                accept, push, qv;
  logic [WB-1:0]       fword, qword;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  lix_front #(.CB(COORD_BITS), .WordBits(WB)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .dir_a_x_i  (dir_a_x_i),
    .dir_a_y_i  (dir_a_y_i),
    .org_a_x_i  (org_a_x_i),
    .org_a_y_i  (org_a_y_i),
    .dir_b_x_i  (dir_b_x_i),
    .dir_b_y_i  (dir_b_y_i),
    .org_b_x_i  (org_b_x_i),
    .org_b_y_i  (org_b_y_i),
    .confined_i (confined_i),
    .push_o     (push),
    .word_o     (fword)
  );

  lix_fifo #(.W(WB)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fword),
    .valid_o (qv),
    .data_o  (qword),
    .busy_o  (busy_o)
  );

  lix_back #(.CB(COORD_BITS), .WordBits(WB)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (qv),
    .word_i   (qword),
    .tol_i    (tol_q),
    .done_o   (done_o),
    .hit_x_o  (hit_x_o),
    .hit_y_o  (hit_y_o),
    .status_o (status_o)
  );

  `ASSERT_PROP(a_par_zero, clk_i, rst_ni,
    done_o && status_o == ST_PARALLEL |-> hit_x_o == '0 && hit_y_o == '0)
  `ASSERT_PROP(a_out_zero, clk_i, rst_ni,
    done_o && status_o == ST_OUTSIDE |-> hit_x_o == '0 && hit_y_o == '0)
  `ASSERT_PROP(a_sat_lim, clk_i, rst_ni,
    done_o && status_o == ST_SAT |-> hit_x_o == HMAX || hit_x_o == HMIN ||
    hit_y_o == HMAX || hit_y_o == HMIN)
  `ASSERT_NEVER(a_no_busy_push, clk_i, rst_ni, busy_o && push && qv && !u_fifo.pop)
endmodule
`default_nettype wire
